### rtl/ttce_pkg.sv
`default_nettype none

package ttce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_FW  = 7;
    localparam int ROW_FW  = 5;
    localparam int SEQ_MAX = 8;
    localparam int LEN_W   = 4;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;

    typedef enum logic [2:0] {
        CLS_FAIL, CLS_PENDING, CLS_CLEAR, CLS_HOME, CLS_EOL, CLS_POS, CLS_COLOR
    } t_cls;

    typedef enum logic [1:0] {
        PC_NUL, PC_NL, PC_BS, PC_CHAR
    } t_pcat;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RD_CELL, OP_RD_CAP, OP_CONSUME, OP_CLR_INIT,
        OP_EOL_INIT, OP_BLANK_STEP, OP_SCR_INIT, OP_SCR_RD, OP_SCR_WR,
        OP_TAIL_INIT, OP_PLAIN_CHAR, OP_NEWLINE, OP_BS_MOVE, OP_BLANK_CUR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cls  cls;
        t_pcat pcat;
        logic  len_zero;
        logic  x_last;
        logic  y_last;
        logic  sweep_last;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/ttce_dp.sv
`default_nettype none

module ttce_dp import ttce_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_data,
    input  wire logic [7:0]            i_byte,
    input  wire logic [ROW_FW-1:0]     i_row,
    input  wire logic [COL_FW-1:0]     i_col,
    output logic [31:0]                o_result
);

    logic [15:0]        r_mem [CELLS];
    logic [15:0]        r_rdata;
    logic               r_rd_ok;
    logic [COL_FW-1:0]  r_x;
    logic [ROW_FW-1:0]  r_y;
    logic [7:0]         r_attr;
    logic [7:0]         r_buf [SEQ_MAX];
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_end;
    logic [7:0]         r_cchar;
    logic [7:0]         r_cattr;
    logic [31:0]        r_out;
    logic               r_esc_en;

    t_cls               cls;
    logic [LEN_W-1:0]   used;
    logic [ADDR_W-1:0]  row_base;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  rd_cell_addr;
    logic               rd_cell_ok;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [15:0]        wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic               pos_ok;
    logic [6:0]         pos_r;
    logic [6:0]         pos_c;
    logic [3:0]         fg;
    logic [3:0]         bg;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    always_comb begin
        cls  = CLS_FAIL;
        used = LEN_W'(1);
        if (!r_esc_en || r_buf[0] != ESC_BYTE) begin
            cls = CLS_FAIL;
        end else if (r_len < LEN_W'(2)) begin
            cls = CLS_PENDING;
        end else if (r_buf[1] != "[") begin
            cls = CLS_FAIL;
        end else if (r_len < LEN_W'(3)) begin
            cls = CLS_PENDING;
        end else if (r_buf[2] == "H") begin
            cls  = CLS_HOME;
            used = LEN_W'(3);
        end else if (r_buf[2] == "K") begin
            cls  = CLS_EOL;
            used = LEN_W'(3);
        end else if (r_len < LEN_W'(4)) begin
            cls = CLS_PENDING;
        end else if (r_buf[2] == "2" && r_buf[3] == "J") begin
            cls  = CLS_CLEAR;
            used = LEN_W'(4);
        end else if (r_len < LEN_W'(5)) begin
            cls = CLS_PENDING;
        end else if (r_buf[4] != ";") begin
            cls = CLS_FAIL;
        end else if (r_len < LEN_W'(8)) begin
            cls = CLS_PENDING;
        end else if (r_buf[7] == "H") begin
            cls  = CLS_POS;
            used = LEN_W'(8);
        end else if (r_buf[7] == "M") begin
            cls  = CLS_COLOR;
            used = LEN_W'(8);
        end
    end

    always_comb begin
        pos_r  = 7'(r_buf[2][3:0]) * 7'd10 + 7'(r_buf[3][3:0]);
        pos_c  = 7'(r_buf[5][3:0]) * 7'd10 + 7'(r_buf[6][3:0]);
        pos_ok = is_digit(r_buf[2]) && is_digit(r_buf[3]) && is_digit(r_buf[5])
                 && is_digit(r_buf[6]) && (int'(pos_r) < ROWS)
                 && (int'(pos_c) < COLUMNS);
        fg = r_buf[3][3:0] + ((r_buf[2] != "3") ? 4'd8 : 4'd0);
        bg = r_buf[6][3:0] + ((r_buf[5] != "4") ? 4'd8 : 4'd0);
    end

    always_comb begin
        row_base     = ADDR_W'(r_y) * ADDR_W'(COLUMNS);
        cur_addr     = row_base + ADDR_W'(r_x);
        rd_cell_addr = ADDR_W'(i_row) * ADDR_W'(COLUMNS) + ADDR_W'(i_col);
        rd_cell_ok   = (int'(i_row) < ROWS) && (int'(i_col) < COLUMNS);
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = {r_attr, BLANK_CHAR};
        re    = 1'b0;
        raddr = rd_cell_addr;
        case (i_cmd.op)
            OP_BLANK_STEP: begin
                we = 1'b1;
            end
            OP_SCR_WR: begin
                we    = 1'b1;
                wdata = r_rdata;
            end
            OP_PLAIN_CHAR: begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = {r_attr, r_buf[0]};
            end
            OP_BLANK_CUR: begin
                we    = 1'b1;
                waddr = cur_addr;
            end
            OP_SCR_RD: begin
                re    = 1'b1;
                raddr = r_addr + ADDR_W'(COLUMNS);
            end
            OP_RD_CELL: begin
                re = rd_cell_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_attr   <= RESET_ATTR;
            r_len    <= '0;
            r_esc_en <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_esc_en <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_len <= r_len + LEN_W'(1);
                end
                OP_CONSUME: begin
                    r_len <= r_len - used;
                    case (cls)
                        CLS_HOME: begin
                            r_x <= '0;
                            r_y <= '0;
                        end
                        CLS_POS: begin
                            if (pos_ok) begin
                                r_x <= COL_FW'(pos_c);
                                r_y <= ROW_FW'(pos_r);
                            end
                        end
                        CLS_COLOR: begin
                            r_attr <= {bg, fg};
                        end
                        default: begin
                        end
                    endcase
                end
                OP_PLAIN_CHAR: begin
                    r_x <= r_x + COL_FW'(1);
                end
                OP_NEWLINE: begin
                    r_x <= '0;
                    if (r_y != ROW_FW'(ROWS - 1)) begin
                        r_y <= r_y + ROW_FW'(1);
                    end
                end
                OP_BS_MOVE: begin
                    if (r_x != '0) begin
                        r_x <= r_x - COL_FW'(1);
                    end else if (r_y != '0) begin
                        r_y <= r_y - ROW_FW'(1);
                        r_x <= COL_FW'(COLUMNS - 1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_buf[r_len[2:0]] <= i_byte;
                r_cchar           <= '0;
                r_cattr           <= '0;
            end
            OP_RD_CELL: begin
                r_rd_ok <= rd_cell_ok;
            end
            OP_RD_CAP: begin
                r_cchar <= r_rd_ok ? r_rdata[7:0]  : 8'h00;
                r_cattr <= r_rd_ok ? r_rdata[15:8] : 8'h00;
            end
            OP_CONSUME: begin
                for (int i = 0; i < SEQ_MAX; i++) begin
                    if (i + int'(used) < SEQ_MAX) begin
                        r_buf[i] <= r_buf[i + int'(used)];
                    end
                end
            end
            OP_CLR_INIT: begin
                r_addr <= '0;
                r_end  <= ADDR_W'(CELLS - 1);
            end
            OP_EOL_INIT: begin
                r_addr <= cur_addr;
                r_end  <= row_base + ADDR_W'(COLUMNS - 1);
            end
            OP_SCR_INIT: begin
                r_addr <= '0;
                r_end  <= ADDR_W'(CELLS - COLUMNS - 1);
            end
            OP_TAIL_INIT: begin
                r_addr <= ADDR_W'(CELLS - COLUMNS);
                r_end  <= ADDR_W'(CELLS - 1);
            end
            OP_BLANK_STEP, OP_SCR_WR: begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out <= {4'b0000, r_x, r_y, r_cattr, r_cchar};
        end
    end

    always_comb begin
        o_stat.cls        = cls;
        o_stat.len_zero   = (r_len == '0);
        o_stat.x_last     = (r_x == COL_FW'(COLUMNS - 1));
        o_stat.y_last     = (r_y == ROW_FW'(ROWS - 1));
        o_stat.sweep_last = (r_addr == r_end);
        case (r_buf[0])
            CH_NUL:       o_stat.pcat = PC_NUL;
            CH_LF, CH_CR: o_stat.pcat = PC_NL;
            CH_BS:        o_stat.pcat = PC_BS;
            default:      o_stat.pcat = PC_CHAR;
        endcase
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

### rtl/ttce_ctrl.sv
`default_nettype none

module ttce_ctrl import ttce_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire logic     i_func,
    output logic          o_s_tready,
    input  wire logic     i_m_tready,
    output logic          o_m_tvalid,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD_CAP, S_DISPATCH, S_CONSUME, S_NL, S_SCR_INIT,
        S_SCR_RD, S_SCR_WR, S_TAIL_INIT, S_SWEEP, S_BS_BLANK, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_init;
    logic   r_m_tvalid;
    logic   n_m_tvalid;
    logic   done_load;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        done_load      = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.op = OP_CLR_INIT;
                n_state  = S_SWEEP;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = i_func ? OP_RD_CELL : OP_LOAD;
                    n_state  = i_func ? S_RD_CAP : S_DISPATCH;
                end
            end
            S_RD_CAP: begin
                o_cmd.op = OP_RD_CAP;
                n_state  = S_DONE;
            end
            S_DISPATCH: begin
                if (i_stat.len_zero) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.cls)
                        CLS_PENDING: n_state = S_DONE;
                        CLS_CLEAR: begin
                            o_cmd.op = OP_CLR_INIT;
                            n_state  = S_SWEEP;
                        end
                        CLS_EOL: begin
                            o_cmd.op = OP_EOL_INIT;
                            n_state  = S_SWEEP;
                        end
                        CLS_FAIL: begin
                            case (i_stat.pcat)
                                PC_NUL: o_cmd.op = OP_CONSUME;
                                PC_NL:  n_state  = S_NL;
                                PC_BS: begin
                                    o_cmd.op = OP_BS_MOVE;
                                    n_state  = S_BS_BLANK;
                                end
                                default: begin
                                    o_cmd.op = OP_PLAIN_CHAR;
                                    n_state  = i_stat.x_last ? S_NL : S_CONSUME;
                                end
                            endcase
                        end
                        default: o_cmd.op = OP_CONSUME;
                    endcase
                end
            end
            S_CONSUME: begin
                o_cmd.op = OP_CONSUME;
                n_state  = S_DISPATCH;
            end
            S_NL: begin
                o_cmd.op = OP_NEWLINE;
                n_state  = i_stat.y_last ? S_SCR_INIT : S_CONSUME;
            end
            S_SCR_INIT: begin
                o_cmd.op = OP_SCR_INIT;
                n_state  = S_SCR_RD;
            end
            S_SCR_RD: begin
                o_cmd.op = OP_SCR_RD;
                n_state  = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.op = OP_SCR_WR;
                n_state  = i_stat.sweep_last ? S_TAIL_INIT : S_SCR_RD;
            end
            S_TAIL_INIT: begin
                o_cmd.op = OP_TAIL_INIT;
                n_state  = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.op = OP_BLANK_STEP;
                if (i_stat.sweep_last) begin
                    n_state = r_init ? S_IDLE : S_CONSUME;
                end
            end
            S_BS_BLANK: begin
                o_cmd.op = OP_BLANK_CUR;
                n_state  = S_CONSUME;
            end
            S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    done_load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.out_load = done_load;
        n_m_tvalid     = done_load | (r_m_tvalid & ~i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
            if (r_state == S_IDLE) begin
                r_init <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;

endmodule

`default_nettype wire

### rtl/text_terminal_cell_engine_unit.sv
// Channel   Direction  Payload
// s (put)   in         tuser: func; tdata: data_byte, read_row, read_col
// m (cell)  out        tdata: cell_char, cell_attr, cursor_row, cursor_col
// cfg       in         escape_enable
//
// Scrolling: a scroll copies each cell of the cell store up one row, with a read
// state and a write state for each cell, then blanks the last row; ESC[2J blanks all.
// Reset: a clearing pass over every cell follows reset; no transfer is taken.
// Stalls: a held result stalls the block at its end; input is taken at idle.
`default_nettype none

module text_terminal_cell_engine_unit import ttce_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // data_byte, read_row, read_col, zero pad
    input  wire logic        i_s_tuser,   // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // cell_char, cell_attr, cursor_row, cursor_col
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data   // escape_enable
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ttce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ttce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (i_s_tdata[7:0]),
        .i_row       (i_s_tdata[12:8]),
        .i_col       (i_s_tdata[19:13]),
        .o_result    (o_m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transfer taken while busy");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((int'(o_m_tdata[20:16]) < ROWS)
                        && (int'(o_m_tdata[27:21]) < COLUMNS)))
        else $error("cursor out of range");

    a_put_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser) |=> (cmd.op != OP_RD_CAP))
        else $error("put item took the read path");
`endif

endmodule

`default_nettype wire
